// ===== sv/mrtu_pkg.sv =====
package mrtu_pkg;

    localparam int REGISTER_DEPTH_DEF = 256;
    localparam int FRAME_BYTES_DEF    = 256;

    localparam int FL_W  = 9;
    localparam int CRC_W = 16;

    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_EOF     = 2'd1;
    localparam logic [1:0] OP_TX_SLOT = 2'd2;

    localparam logic [1:0] CFG_OWN_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_HIGH_FIRST  = 2'd1;
    localparam logic [1:0] CFG_REGS_IN_USE = 2'd2;

    localparam logic [1:0] KIND_EXCEPTION = 2'd1;
    localparam logic [1:0] KIND_READ      = 2'd2;
    localparam logic [1:0] KIND_ECHO      = 2'd3;

    localparam logic [7:0] FN_READ_HOLD  = 8'h03;
    localparam logic [7:0] FN_READ_INPUT = 8'h04;
    localparam logic [7:0] FN_WRITE_ONE  = 8'h06;
    localparam logic [7:0] FN_WRITE_MANY = 8'h10;

    localparam logic [3:0] EXC_ILLEGAL_FN   = 4'h1;
    localparam logic [3:0] EXC_ILLEGAL_ADDR = 4'h2;
    localparam logic [3:0] EXC_ILLEGAL_DATA = 4'h3;

    localparam logic [7:0]       EXC_FLAG = 8'h80;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    localparam logic [15:0] READ_QTY_MAX  = 16'd125;
    localparam logic [15:0] WRITE_QTY_MAX = 16'd123;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/modbus_rtu_slave_engine.sv =====
// A transmit slot gives its reply byte through the register store read, then the output
// register. Received bytes and end-of-frame marks are taken one per cycle while the block
// is idle and the output is not stalled; a transmit slot holds the block until its byte is
// registered, and a write-many frame holds it through S_WR0, S_WR1, S_WR2 per register after its mark.
// Reset: control clears at once, then a clearing pass zeroes the register store, one entry
// a cycle, during which no item is accepted.
module modbus_rtu_slave_engine
    import mrtu_pkg::*;
#(
    parameter int REGISTER_DEPTH = REGISTER_DEPTH_DEF,
    parameter int FRAME_BYTES    = FRAME_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] tx_byte,
    output logic       tx_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    localparam int RA_W = (REGISTER_DEPTH > 1) ? $clog2(REGISTER_DEPTH) : 1;
    localparam int FA_W = $clog2(FRAME_BYTES);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WR0   = 3'd2;
    localparam logic [2:0] S_WR1   = 3'd3;
    localparam logic [2:0] S_WR2   = 3'd4;
    localparam logic [2:0] S_TX    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [RA_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic [7:0] own_addr_reg;
    logic       hbf_reg;
    logic [8:0] riu_reg;

    logic [7:0] frame_mem [FRAME_BYTES];
    logic [15:0] reg_mem [REGISTER_DEPTH];
    logic [7:0] frame_rdata_reg;
    logic [15:0] reg_rdata_reg;

    logic [7:0] hdr_reg [7];
    logic [FL_W-1:0] flen_reg, flen_next;
    logic fovf_reg, fovf_next;
    logic [CRC_W-1:0] rcrc_reg, rcrc_next;

    logic reply_active_reg, reply_active_next;
    logic [1:0] kind_reg, kind_next;
    logic [3:0] code_reg, code_next;
    logic [FL_W-1:0] ridx_reg, ridx_next;
    logic [FL_W-1:0] rlen_reg, rlen_next;
    logic [CRC_W-1:0] tcrc_reg, tcrc_next;

    logic [6:0] wr_cnt_reg, wr_cnt_next;
    logic [6:0] wr_qty_reg, wr_qty_next;
    logic [7:0] wr_b0_reg, wr_b0_next;

    logic out_valid_reg, out_valid_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic tx_last_reg, tx_last_next;

    logic in_acc;
    logic hdr_we;
    logic frame_we;
    logic [FA_W-1:0] frame_waddr, frame_raddr;
    logic reg_we;
    logic [RA_W-1:0] reg_waddr, reg_raddr;
    logic [15:0] reg_wdata;

    logic [7:0] fn;
    logic [15:0] start_w, qty_w;
    logic [16:0] lim, end_w;
    logic [9:0] wm_len;
    logic [8:0] k;
    logic [8:0] fptr;
    logic [7:0] body;

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign tx_last   = tx_last_reg;

    assign fn      = hdr_reg[1];
    assign start_w = {hdr_reg[2], hdr_reg[3]};
    assign qty_w   = {hdr_reg[4], hdr_reg[5]};
    assign lim     = (17'(riu_reg) > 17'(REGISTER_DEPTH)) ? 17'(REGISTER_DEPTH) : 17'(riu_reg);
    assign end_w   = {1'b0, start_w} + {1'b0, qty_w};
    assign wm_len  = 10'd9 + {2'b00, hdr_reg[6]};
    assign k       = ridx_reg - 9'd3;

    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        flen_next         = flen_reg;
        fovf_next         = fovf_reg;
        rcrc_next         = rcrc_reg;
        reply_active_next = reply_active_reg;
        kind_next         = kind_reg;
        code_next         = code_reg;
        ridx_next         = ridx_reg;
        rlen_next         = rlen_reg;
        tcrc_next         = tcrc_reg;
        wr_cnt_next       = wr_cnt_reg;
        wr_qty_next       = wr_qty_reg;
        wr_b0_next        = wr_b0_reg;
        out_valid_next    = out_valid_reg && out_stall;
        tx_byte_next      = tx_byte_reg;
        tx_last_next      = tx_last_reg;
        hdr_we            = 1'b0;
        frame_we          = 1'b0;
        frame_waddr       = flen_reg[FA_W-1:0];
        fptr              = 9'd7 + {1'b0, wr_cnt_reg, 1'b0};
        frame_raddr       = fptr[FA_W-1:0];
        reg_we            = 1'b0;
        reg_waddr         = clr_cnt_reg;
        reg_wdata         = 16'h0000;
        reg_raddr         = RA_W'(start_w + {8'h00, k[8:1]});
        body              = 8'h00;

        unique case (state_reg)
            S_CLEAR:
            begin
                reg_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == RA_W'(REGISTER_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc && operation == OP_RX_BYTE && !reply_active_reg)
                begin
                    hdr_we = (flen_reg < 9'd7);
                    if (flen_reg < 9'(FRAME_BYTES))
                    begin
                        frame_we  = 1'b1;
                        flen_next = flen_reg + 1'b1;
                    end
                    else
                    begin
                        fovf_next = 1'b1;
                    end
                    rcrc_next = crc_byte(rcrc_reg, rx_byte);
                end
                else if (in_acc && operation == OP_EOF && !reply_active_reg)
                begin
                    flen_next = '0;
                    fovf_next = 1'b0;
                    rcrc_next = CRC_INIT;
                    if (!fovf_reg && flen_reg >= 9'd2
                        && (((fn == FN_READ_HOLD || fn == FN_READ_INPUT || fn == FN_WRITE_ONE)
                             && flen_reg == 9'd8)
                            || (fn == FN_WRITE_MANY && flen_reg >= 9'd9
                                && {1'b0, flen_reg} == wm_len)
                            || (fn != FN_READ_HOLD && fn != FN_READ_INPUT
                                && fn != FN_WRITE_ONE && fn != FN_WRITE_MANY
                                && flen_reg >= 9'd4))
                        && rcrc_reg == '0
                        && (hdr_reg[0] == own_addr_reg || hdr_reg[0] == 8'h00))
                    begin
                        ridx_next = '0;
                        tcrc_next = CRC_INIT;
                        rlen_next = 9'd5;
                        code_next = '0;
                        kind_next = KIND_EXCEPTION;
                        reply_active_next = 1'b1;
                        priority if (fn == FN_READ_HOLD || fn == FN_READ_INPUT)
                        begin
                            if (qty_w == 16'd0 || qty_w > READ_QTY_MAX)
                            begin
                                code_next = EXC_ILLEGAL_DATA;
                            end
                            else if (end_w > lim)
                            begin
                                code_next = EXC_ILLEGAL_ADDR;
                            end
                            else
                            begin
                                kind_next = KIND_READ;
                                rlen_next = 9'd5 + {qty_w[7:0], 1'b0};
                            end
                        end
                        else if (fn == FN_WRITE_ONE)
                        begin
                            if ({1'b0, start_w} >= lim)
                            begin
                                code_next = EXC_ILLEGAL_ADDR;
                            end
                            else
                            begin
                                reg_we    = 1'b1;
                                reg_waddr = RA_W'(start_w);
                                reg_wdata = hbf_reg ? {hdr_reg[4], hdr_reg[5]}
                                                    : {hdr_reg[5], hdr_reg[4]};
                                kind_next = KIND_ECHO;
                                rlen_next = 9'd8;
                            end
                        end
                        else if (fn == FN_WRITE_MANY)
                        begin
                            if (qty_w == 16'd0 || qty_w > WRITE_QTY_MAX
                                || {8'h00, hdr_reg[6]} != {qty_w[14:0], 1'b0})
                            begin
                                code_next = EXC_ILLEGAL_DATA;
                            end
                            else if (end_w > lim)
                            begin
                                code_next = EXC_ILLEGAL_ADDR;
                            end
                            else
                            begin
                                // reply starts once all writes are done
                                reply_active_next = 1'b0;
                                wr_cnt_next = '0;
                                wr_qty_next = qty_w[6:0];
                                state_next  = S_WR0;
                            end
                        end
                        else
                        begin
                            code_next = EXC_ILLEGAL_FN;
                        end
                    end
                end
                else if (in_acc && operation == OP_TX_SLOT && reply_active_reg)
                begin
                    state_next = S_TX;
                end
            end
            S_WR0:
            begin
                state_next = S_WR1;
            end
            S_WR1:
            begin
                fptr        = 9'd8 + {1'b0, wr_cnt_reg, 1'b0};
                frame_raddr = fptr[FA_W-1:0];
                wr_b0_next  = frame_rdata_reg;
                state_next  = S_WR2;
            end
            S_WR2:
            begin
                reg_we      = 1'b1;
                reg_waddr   = RA_W'(start_w + {9'h000, wr_cnt_reg});
                reg_wdata   = hbf_reg ? {wr_b0_reg, frame_rdata_reg}
                                      : {frame_rdata_reg, wr_b0_reg};
                wr_cnt_next = wr_cnt_reg + 1'b1;
                if (wr_cnt_reg + 1'b1 == wr_qty_reg)
                begin
                    reply_active_next = 1'b1;
                    kind_next  = KIND_ECHO;
                    code_next  = '0;
                    ridx_next  = '0;
                    rlen_next  = 9'd8;
                    tcrc_next  = CRC_INIT;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_WR0;
                end
            end
            S_TX:
            begin
                priority if (kind_reg == KIND_EXCEPTION)
                begin
                    if (ridx_reg == 9'd0)
                        body = hdr_reg[0];
                    else if (ridx_reg == 9'd1)
                        body = hdr_reg[1] | EXC_FLAG;
                    else
                        body = {4'h0, code_reg};
                end
                else if (kind_reg == KIND_READ)
                begin
                    if (ridx_reg == 9'd0)
                        body = hdr_reg[0];
                    else if (ridx_reg == 9'd1)
                        body = hdr_reg[1];
                    else if (ridx_reg == 9'd2)
                        body = 8'(rlen_reg - 9'd5);
                    else if (k[0] != hbf_reg)
                        body = reg_rdata_reg[15:8];
                    else
                        body = reg_rdata_reg[7:0];
                end
                else
                begin
                    body = (ridx_reg < 9'd7) ? hdr_reg[ridx_reg[2:0]] : 8'h00;
                end

                out_valid_next = 1'b1;
                tx_last_next   = 1'b0;
                ridx_next      = ridx_reg + 1'b1;
                if ({1'b0, ridx_reg} + 10'd2 < {1'b0, rlen_reg})
                begin
                    tx_byte_next = body;
                    tcrc_next    = crc_byte(tcrc_reg, body);
                end
                else if ({1'b0, ridx_reg} + 10'd2 == {1'b0, rlen_reg})
                begin
                    tx_byte_next = tcrc_reg[7:0];
                end
                else
                begin
                    tx_byte_next      = tcrc_reg[15:8];
                    tx_last_next      = 1'b1;
                    reply_active_next = 1'b0;
                    ridx_next         = '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= rx_byte;
        end
        frame_rdata_reg <= frame_mem[frame_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (reg_we)
        begin
            reg_mem[reg_waddr] <= reg_wdata;
        end
        reg_rdata_reg <= reg_mem[reg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[flen_reg[2:0]] <= rx_byte;
        end
        wr_b0_reg    <= wr_b0_next;
        tx_byte_reg  <= tx_byte_next;
        tx_last_reg  <= tx_last_next;
        code_reg     <= code_next;
        rlen_reg     <= rlen_next;
        tcrc_reg     <= tcrc_next;
        wr_qty_reg   <= wr_qty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            own_addr_reg     <= 8'd1;
            hbf_reg          <= 1'b1;
            riu_reg          <= 9'd256;
            flen_reg         <= '0;
            fovf_reg         <= 1'b0;
            rcrc_reg         <= CRC_INIT;
            reply_active_reg <= 1'b0;
            kind_reg         <= '0;
            ridx_reg         <= '0;
            wr_cnt_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            flen_reg         <= flen_next;
            fovf_reg         <= fovf_next;
            rcrc_reg         <= rcrc_next;
            reply_active_reg <= reply_active_next;
            kind_reg         <= kind_next;
            ridx_reg         <= ridx_next;
            wr_cnt_reg       <= wr_cnt_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_OWN_ADDRESS)
                    own_addr_reg <= cfg_data[7:0];
                else if (cfg_index == CFG_HIGH_FIRST)
                    hbf_reg <= cfg_data[0];
                else if (cfg_index == CFG_REGS_IN_USE)
                    riu_reg <= cfg_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_out_from_tx: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_TX)
        else $error("result appeared without a transmit step");

    a_last_ends_reply: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == S_TX && tx_last_reg) |-> !reply_active_reg)
        else $error("reply still active after its final byte");

    a_wr_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR0 |-> wr_cnt_reg < wr_qty_reg)
        else $error("write-many loop ran past its quantity");

    a_no_reply_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR0 || state_reg == S_WR1 || state_reg == S_WR2)
        |-> !reply_active_reg)
        else $error("reply pending during register writes");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mrtu_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] operation = OP_RX_BYTE;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_OWN_ADDRESS;
    logic [8:0] cfg_data = 9'd0;

    modbus_rtu_slave_engine dut (.*);

    always #4 clk = ~clk;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tx_item_t;

    // slave image kept by the testbench
    logic [7:0]  m_own;
    logic        m_hi_first;
    logic [8:0]  m_regs_used;
    logic [7:0]  m_frame [256];
    int          m_flen;
    logic        m_ovf;
    logic [15:0] m_rx_crc;
    logic [15:0] m_regs [256];
    logic        m_active;
    logic [1:0]  m_kind;
    logic [3:0]  m_code;
    int          m_idx;
    int          m_rlen;
    logic [15:0] m_tx_crc;

    tx_item_t reply_bytes_q[$];
    int       mismatches = 0;
    int       stall_left = 0;

    function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] fbyte(int i);
        return (i < 256) ? m_frame[i] : 8'h00;
    endfunction

    function automatic void model_reset();
        m_own = 8'd1;
        m_hi_first = 1'b1;
        m_regs_used = 9'd256;
        m_flen = 0;
        m_ovf = 1'b0;
        m_rx_crc = 16'hFFFF;
        for (int i = 0; i < 256; i++)
        begin
            m_regs[i] = 16'h0000;
            m_frame[i] = 8'h00;
        end
        m_active = 1'b0;
    endfunction

    function automatic void begin_reply(logic [1:0] kind, logic [3:0] code, int len);
        m_active = 1'b1;
        m_kind = kind;
        m_code = code;
        m_idx = 0;
        m_rlen = len;
        m_tx_crc = 16'hFFFF;
    endfunction

    function automatic void store_word(int addr, logic [7:0] b0, logic [7:0] b1);
        if (addr < 256)
        begin
            m_regs[addr] = m_hi_first ? {b0, b1} : {b1, b0};
        end
    endfunction

    function automatic void serve_request();
        logic [7:0] fn;
        int         start;
        int         qty;
        int         lim;
        if (m_ovf || m_flen < 2)
        begin
            return;
        end
        fn = fbyte(1);
        if (fn == FN_READ_HOLD || fn == FN_READ_INPUT || fn == FN_WRITE_ONE)
        begin
            if (m_flen != 8)
            begin
                return;
            end
        end
        else if (fn == FN_WRITE_MANY)
        begin
            if (m_flen < 9 || m_flen != 9 + fbyte(6))
            begin
                return;
            end
        end
        else if (m_flen < 4)
        begin
            return;
        end
        if (m_rx_crc != 16'h0000)
        begin
            return;
        end
        if (fbyte(0) != m_own && fbyte(0) != 8'h00)
        begin
            return;
        end
        if (fn != FN_READ_HOLD && fn != FN_READ_INPUT && fn != FN_WRITE_ONE
            && fn != FN_WRITE_MANY)
        begin
            begin_reply(KIND_EXCEPTION, EXC_ILLEGAL_FN, 5);
            return;
        end
        start = int'({fbyte(2), fbyte(3)});
        qty = int'({fbyte(4), fbyte(5)});
        lim = (m_regs_used > 256) ? 256 : int'(m_regs_used);
        if (fn == FN_READ_HOLD || fn == FN_READ_INPUT)
        begin
            if (qty == 0 || qty > 125)
            begin
                begin_reply(KIND_EXCEPTION, EXC_ILLEGAL_DATA, 5);
            end
            else if (start + qty > lim)
            begin
                begin_reply(KIND_EXCEPTION, EXC_ILLEGAL_ADDR, 5);
            end
            else
            begin
                begin_reply(KIND_READ, 4'h0, 5 + 2 * qty);
            end
        end
        else if (fn == FN_WRITE_ONE)
        begin
            if (start >= lim)
            begin
                begin_reply(KIND_EXCEPTION, EXC_ILLEGAL_ADDR, 5);
            end
            else
            begin
                store_word(start, fbyte(4), fbyte(5));
                begin_reply(KIND_ECHO, 4'h0, 8);
            end
        end
        else
        begin
            if (qty == 0 || qty > 123 || fbyte(6) != 2 * qty)
            begin
                begin_reply(KIND_EXCEPTION, EXC_ILLEGAL_DATA, 5);
            end
            else if (start + qty > lim)
            begin
                begin_reply(KIND_EXCEPTION, EXC_ILLEGAL_ADDR, 5);
            end
            else
            begin
                for (int i = 0; i < qty; i++)
                begin
                    store_word(start + i, fbyte(7 + 2 * i), fbyte(8 + 2 * i));
                end
                begin_reply(KIND_ECHO, 4'h0, 8);
            end
        end
    endfunction

    function automatic logic [7:0] reply_body(int idx);
        int         k;
        int         reg_addr;
        logic [15:0] w;
        logic        hi_slot;
        if (m_kind == KIND_EXCEPTION)
        begin
            if (idx == 0) return fbyte(0);
            if (idx == 1) return fbyte(1) | EXC_FLAG;
            return {4'h0, m_code};
        end
        if (m_kind == KIND_READ)
        begin
            if (idx == 0) return fbyte(0);
            if (idx == 1) return fbyte(1);
            if (idx == 2) return 8'(m_rlen - 5);
            k = idx - 3;
            reg_addr = int'({fbyte(2), fbyte(3)}) + (k >> 1);
            w = (reg_addr < 256) ? m_regs[reg_addr] : 16'h0000;
            hi_slot = ((k & 1) == 0);
            return (m_hi_first ? hi_slot : !hi_slot) ? w[15:8] : w[7:0];
        end
        return fbyte(idx);
    endfunction

    // advance the image by one transaction, queueing any reply byte
    function automatic void predict_item(logic [1:0] op, logic [7:0] b);
        tx_item_t t;
        if (op == OP_RX_BYTE)
        begin
            if (m_active) return;
            if (m_flen < 256)
            begin
                m_frame[m_flen] = b;
                m_flen++;
            end
            else
            begin
                m_ovf = 1'b1;
            end
            m_rx_crc = crc_step(m_rx_crc, b);
        end
        else if (op == OP_EOF)
        begin
            if (m_active) return;
            serve_request();
            m_flen = 0;
            m_ovf = 1'b0;
            m_rx_crc = 16'hFFFF;
        end
        else if (op == OP_TX_SLOT && m_active)
        begin
            t.last = 1'b0;
            if (m_idx + 2 < m_rlen)
            begin
                t.data = reply_body(m_idx);
                m_tx_crc = crc_step(m_tx_crc, t.data);
            end
            else if (m_idx + 2 == m_rlen)
            begin
                t.data = m_tx_crc[7:0];
            end
            else
            begin
                t.data = m_tx_crc[15:8];
                t.last = 1'b1;
            end
            if (t.last)
            begin
                m_active = 1'b0;
                m_idx = 0;
            end
            else
            begin
                m_idx++;
            end
            reply_bytes_q.push_back(t);
        end
    endfunction

    // valid stays high into the next transaction when no idle cycles are drawn
    task automatic send_item(logic [1:0] op, logic [7:0] b);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_item(op, b);
    endtask

    task automatic drain_replies();
        while (m_active)
        begin
            send_item(OP_TX_SLOT, 8'($urandom_range(0, 255)));
        end
        in_valid <= 1'b0;
        while (reply_bytes_q.size() != 0) @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_OWN_ADDRESS) m_own = val[7:0];
        else if (idx == CFG_HIGH_FIRST) m_hi_first = val[0];
        else if (idx == CFG_REGS_IN_USE) m_regs_used = val;
        @(posedge clk);
    endtask

    // frame with CRC appended (optionally corrupted), then end of frame
    task automatic send_frame(logic [7:0] body[$], bit bad_crc);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (body[i])
        begin
            c = crc_step(c, body[i]);
            send_item(OP_RX_BYTE, body[i]);
        end
        if (bad_crc) c ^= 16'h0100 << $urandom_range(0, 7);
        send_item(OP_RX_BYTE, c[7:0]);
        send_item(OP_RX_BYTE, c[15:8]);
        send_item(OP_EOF, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return m_own;
        if (r < 9) return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic request(logic [7:0] addr, logic [7:0] fn, logic [15:0] start,
                           logic [15:0] qty, int nwords, bit bad_crc);
        logic [7:0] body[$];
        body = {addr, fn, start[15:8], start[7:0], qty[15:8], qty[7:0]};
        if (fn == FN_WRITE_MANY)
        begin
            body.push_back(8'(2 * nwords));
            for (int i = 0; i < 2 * nwords; i++)
            begin
                body.push_back(8'($urandom_range(0, 255)));
            end
        end
        send_frame(body, bad_crc);
        drain_replies();
    endtask

    task automatic test_directed();
        request(m_own, FN_WRITE_ONE, 16'd0, 16'hFFFF, 0, 0);
        request(m_own, FN_WRITE_ONE, 16'd255, 16'h0000, 0, 0);
        request(m_own, FN_WRITE_MANY, 16'd3, 16'd4, 4, 0);
        request(m_own, FN_READ_HOLD, 16'd0, 16'd8, 0, 0);
        request(8'h00, FN_READ_INPUT, 16'd250, 16'd6, 0, 0);
        request(m_own, FN_READ_HOLD, 16'd0, 16'd0, 0, 0);
        request(m_own, FN_READ_HOLD, 16'd0, 16'd126, 0, 0);
        request(m_own, FN_READ_HOLD, 16'd200, 16'd100, 0, 0);
        request(m_own, FN_READ_HOLD, 16'hFFFF, 16'd1, 0, 0);
        request(m_own, FN_WRITE_ONE, 16'd256, 16'd1, 0, 0);
        request(m_own, FN_WRITE_MANY, 16'd0, 16'd124, 2, 0);
        request(m_own, FN_WRITE_MANY, 16'd0, 16'd3, 2, 0);
        request(m_own, FN_WRITE_MANY, 16'd254, 16'd3, 3, 0);
        request(m_own, 8'h2B, 16'd1, 16'd1, 0, 0);
        request(m_own, FN_READ_HOLD, 16'd0, 16'd2, 0, 1);
        request(8'hF7, FN_READ_HOLD, 16'd0, 16'd2, 0, 0);
        send_item(OP_TX_SLOT, 8'h00);
        send_item(OP_NONE, 8'hFF);
        send_item(OP_EOF, 8'h00);
        send_item(OP_RX_BYTE, 8'h01);
        send_item(OP_EOF, 8'h00);
        drain_replies();
    endtask

    task automatic test_overflow();
        for (int i = 0; i < 257; i++)
        begin
            send_item(OP_RX_BYTE, 8'($urandom_range(0, 255)));
        end
        send_item(OP_EOF, 8'h00);
        drain_replies();
    endtask

    // random traffic; rx bytes during a reply are ignored by the slave
    task automatic test_random(int n_frames);
        logic [7:0]  fns[5];
        logic [7:0]  fn;
        logic [15:0] start;
        logic [15:0] qty;
        int          nw;
        logic [7:0]  body[$];
        fns = '{FN_READ_HOLD, FN_READ_INPUT, FN_WRITE_ONE, FN_WRITE_MANY, 8'h00};
        for (int f = 0; f < n_frames; f++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                body = {};
                repeat ($urandom_range(0, 12)) body.push_back(8'($urandom_range(0, 255)));
                foreach (body[i]) send_item(OP_RX_BYTE, body[i]);
                send_item(OP_EOF, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 3)) send_item(OP_TX_SLOT, 8'h00);
                continue;
            end
            fn = fns[$urandom_range(0, 4)];
            if (fn == 8'h00) fn = 8'($urandom_range(0, 255));
            start = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 260));
            nw = $urandom_range(1, 4);
            qty = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(nw);
            if (fn == FN_READ_HOLD || fn == FN_READ_INPUT)
            begin
                qty = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 130)) : qty;
            end
            body = {pick_addr(), fn, start[15:8], start[7:0], qty[15:8], qty[7:0]};
            if (fn == FN_WRITE_MANY)
            begin
                body.push_back(8'(2 * nw));
                for (int i = 0; i < 2 * nw; i++) body.push_back(8'($urandom_range(0, 255)));
            end
            send_frame(body, $urandom_range(0, 11) == 0);
            while (m_active)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_item(OP_RX_BYTE, 8'($urandom_range(0, 255)));
                else
                    send_item(OP_TX_SLOT, 8'($urandom_range(0, 255)));
            end
        end
        drain_replies();
    endtask

    // reply checker
    always @(posedge clk)
    begin
        tx_item_t exp_t;
        if (out_valid && !out_stall)
        begin
            if (reply_bytes_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply byte %h last %b", tx_byte, tx_last);
            end
            else
            begin
                exp_t = reply_bytes_q.pop_front();
                if (tx_byte !== exp_t.data || tx_last !== exp_t.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply byte exp %h/%b got %h/%b",
                                 exp_t.data, exp_t.last, tx_byte, tx_last);
                end
            end
        end
    end

    // receiver waits a drawn number of cycles after each reply byte
    always @(posedge clk)
    begin
        int n;
        if (out_valid && !out_stall)
        begin
            n = $urandom_range(0, 19);
            stall_left <= n;
            out_stall <= (n != 0);
        end
        else if (out_stall)
        begin
            if (stall_left <= 1) out_stall <= 1'b0;
            stall_left <= stall_left - 1;
        end
    end

    initial
    begin
        model_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_cfg(CFG_REGS_IN_USE, 9'd256);
        test_directed();
        test_overflow();
        test_random(3);
        write_cfg(CFG_OWN_ADDRESS, 9'd247);
        write_cfg(CFG_HIGH_FIRST, 9'd0);
        write_cfg(CFG_REGS_IN_USE, 9'd0);
        test_random(2);
        write_cfg(CFG_REGS_IN_USE, 9'd37);
        write_cfg(CFG_OWN_ADDRESS, 9'd1);
        test_random(2);
        write_cfg(CFG_HIGH_FIRST, 9'd1);
        write_cfg(CFG_OWN_ADDRESS, 9'd100);
        write_cfg(CFG_REGS_IN_USE, 9'd256);
        test_random(2);
        drain_replies();
        if (mismatches == 0 && reply_bytes_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== modbus_rtu_slave_engine.f =====
sv/mrtu_pkg.sv
sv/modbus_rtu_slave_engine.sv
tb/sv/testbench.sv
